// ===== sv/fcd_pkg.sv =====
// Shared types, byte codes and reply tables for the framed command decoder.
// No dependencies; used by every module of the block.
package fcd_pkg;

  localparam logic [7:0] AsciiA = 8'h41;
  localparam logic [7:0] AsciiT = 8'h54;
  localparam logic [7:0] AsciiS = 8'h53;
  localparam logic [7:0] AsciiE = 8'h45;

  localparam logic [7:0] CmdPing    = 8'h01;
  localparam logic [7:0] CmdTempRd  = 8'h02;
  localparam logic [7:0] CmdFanRd   = 8'h03;
  localparam logic [7:0] CmdFanCtl  = 8'h06;
  localparam logic [7:0] CmdHeatCtl = 8'h07;

  localparam logic [7:0] ErrNoSensor = 8'h01;
  localparam logic [7:0] ErrRefused  = 8'h02;
  localparam logic [7:0] AckTrailer  = 8'hFF;
  localparam logic [7:0] LevelOff    = 8'h00;
  localparam logic [7:0] LevelOn     = 8'h01;

  localparam logic [14:0] FcdHeaterMinReset = 15'd100;
  localparam int unsigned FcdQueueDepth = 2;

  typedef struct packed {
    logic [7:0]         rx_byte;
    logic [14:0]        fan_speed;
    logic signed [15:0] temperature;
    logic               sensor_present;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       fan_drive;
    logic       heater_drive;
  } out_word_t;

  typedef enum logic [2:0] {
    RplPing,
    RplFanRd,
    RplTempOk,
    RplTempErr,
    RplFanAck,
    RplHeatAck,
    RplHeatNak
  } reply_kind_e;

  typedef struct packed {
    reply_kind_e kind;
    logic [15:0] data;
    logic        fan;
    logic        heater;
  } reply_job_t;

  function automatic logic [2:0] reply_len(reply_kind_e kind);
    logic [2:0] len;
    case (kind)
      RplPing:                          len = 3'd3;
      RplFanAck, RplHeatAck, RplHeatNak: len = 3'd4;
      default:                          len = 3'd7;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] reply_byte_at(reply_kind_e kind, logic [2:0] idx,
                                               logic [15:0] data);
    logic [7:0] b;
    case (idx)
      3'd0: b = AsciiA;
      3'd1: b = (kind == RplTempErr || kind == RplHeatNak) ? AsciiE : AsciiS;
      3'd2: begin
        case (kind)
          RplPing:    b = CmdPing;
          RplFanRd:   b = CmdFanRd;
          RplTempOk:  b = CmdTempRd;
          RplTempErr: b = ErrNoSensor;
          RplFanAck:  b = CmdFanCtl;
          RplHeatAck: b = CmdHeatCtl;
          default:    b = ErrRefused;
        endcase
      end
      3'd3: b = (reply_len(kind) == 3'd4) ? AckTrailer : 8'h00;
      3'd5: b = data[15:8];
      3'd6: b = data[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/framed_command_decoder_core.sv =====
// Top level of the framed command decoder: parser, reply queue, reply generator.
// Depends on fcd_pkg, fcd_parser, fcd_job_fifo and fcd_reply_gen.
//
// Takes one bus byte per input word and, after an 'A','T' header and a command,
// answers with a reply of 3, 4 or 7 bytes, one byte per output word, the last one
// flagged and each carrying the fan and heater drive levels. Input words are taken
// every cycle as long as the reply queue (QueueDepth jobs) has room; the generator
// sends one byte per cycle while the output is not stalled and starts the next queued
// reply right after the last byte of the previous one. The output port is the limit
// on sustained rate.
module framed_command_decoder_core import fcd_pkg::*; #(
  parameter int unsigned QueueDepth = FcdQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  logic       accept;
  logic       push, full, pop, head_v;
  reply_job_t push_job, head_job;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  fcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .word_i      (in_word_i),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  fcd_job_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_v),
    .head_o      (head_job)
  );

  fcd_reply_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_v),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== sv/fcd_parser.sv =====
// Front end: header/command parser, drive levels and the heater threshold register.
// Depends on fcd_pkg; emits one reply job per completed command.
module fcd_parser import fcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        accept_i,
  input  in_word_t    word_i,
  output logic        job_valid_o,
  output reply_job_t  job_o
);

  localparam logic [2:0] PhHdrA    = 3'd0;
  localparam logic [2:0] PhHdrT    = 3'd1;
  localparam logic [2:0] PhCmd     = 3'd2;
  localparam logic [2:0] PhFanCtl  = 3'd3;
  localparam logic [2:0] PhFanRd   = 3'd4;
  localparam logic [2:0] PhTempRd  = 3'd5;
  localparam logic [2:0] PhHeatCtl = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic        seen_q, seen_d;
  logic        fan_q, fan_d;
  logic        heat_q, heat_d;
  logic [14:0] min_speed_q;
  logic        job_v;
  reply_kind_e kind;
  logic [15:0] data;

  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    fan_d   = fan_q;
    heat_d  = heat_q;
    job_v   = 1'b0;
    kind    = RplPing;
    data    = 16'h0000;
    case (phase_q)
      PhHdrT: phase_d = (word_i.rx_byte == AsciiT) ? PhCmd : PhHdrA;
      PhCmd: begin
        case (word_i.rx_byte)
          CmdPing: begin
            phase_d = PhHdrA;
            job_v   = 1'b1;
          end
          CmdTempRd:  phase_d = PhTempRd;
          CmdFanRd:   phase_d = PhFanRd;
          CmdFanCtl:  phase_d = PhFanCtl;
          CmdHeatCtl: phase_d = PhHeatCtl;
          default:    phase_d = PhCmd;
        endcase
      end
      PhFanCtl: begin
        phase_d = PhHdrA;
        job_v   = 1'b1;
        kind    = RplFanAck;
        if (word_i.rx_byte == LevelOff) fan_d = 1'b0;
        else if (word_i.rx_byte == LevelOn) fan_d = 1'b1;
      end
      PhFanRd: begin
        phase_d = PhHdrA;
        job_v   = 1'b1;
        kind    = RplFanRd;
        data    = {1'b0, word_i.fan_speed};
      end
      PhTempRd: begin
        phase_d = PhHdrA;
        job_v   = 1'b1;
        if (seen_q || word_i.sensor_present) begin
          seen_d = 1'b1;
          kind   = RplTempOk;
          data   = word_i.temperature;
        end else begin
          kind = RplTempErr;
        end
      end
      PhHeatCtl: begin
        phase_d = PhHdrA;
        job_v   = 1'b1;
        kind    = RplHeatAck;
        if (word_i.rx_byte == LevelOff) begin
          heat_d = 1'b0;
        end else if (word_i.rx_byte == LevelOn) begin
          if (word_i.fan_speed > min_speed_q) heat_d = 1'b1;
          else kind = RplHeatNak;
        end
      end
      default: phase_d = (word_i.rx_byte == AsciiA) ? PhHdrT : PhHdrA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdrA;
      seen_q      <= 1'b0;
      fan_q       <= 1'b0;
      heat_q      <= 1'b0;
      min_speed_q <= FcdHeaterMinReset;
    end else begin
      if (cfg_we_i) min_speed_q <= cfg_wdata_i;
      if (accept_i) begin
        phase_q <= phase_d;
        seen_q  <= seen_d;
        fan_q   <= fan_d;
        heat_q  <= heat_d;
      end
    end
  end

  assign job_valid_o  = accept_i && job_v;
  assign job_o.kind   = kind;
  assign job_o.data   = data;
  assign job_o.fan    = fan_d;
  assign job_o.heater = heat_d;

endmodule

// ===== sv/fcd_job_fifo.sv =====
// Short queue of reply jobs between the parser and the reply generator.
// Depends on fcd_pkg for the job type.
module fcd_job_fifo import fcd_pkg::*; #(
  parameter int unsigned Depth = FcdQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  reply_job_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output reply_job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  reply_job_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("fifo count over depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("fifo pop while empty");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != FullCnt) else $error("fifo push while full");
`endif

endmodule

// ===== sv/fcd_reply_gen.sv =====
// Back end: expands one reply job into its byte run behind an output register.
// Depends on fcd_pkg for reply tables and word types.
module fcd_reply_gen import fcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  reply_job_t job_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  reply_job_t cur_q;
  logic [2:0] idx_q;
  logic       busy_q;
  logic       out_valid_q;
  out_word_t  out_q;
  logic       adv, last, pop;

  assign adv  = busy_q && (!out_valid_q || !out_stall_i);
  assign last = (idx_q == reply_len(cur_q.kind) - 3'd1);
  assign pop  = job_valid_i && (!busy_q || (adv && last));

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= job_i;
    if (adv) begin
      out_q.reply_byte   <= reply_byte_at(cur_q.kind, idx_q, cur_q.data);
      out_q.reply_last   <= last;
      out_q.fan_drive    <= cur_q.fan;
      out_q.heater_drive <= cur_q.heater;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        busy_q <= !last;
        idx_q  <= idx_q + 3'd1;
      end
      if (adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign job_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q < reply_len(cur_q.kind)) else $error("reply index past length");
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> busy_q && idx_q == '0) else $error("job pop did not start a run");
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q) else $error("emitted word not presented");
`endif

endmodule

// ===== tb/sv/fcd_reply_checker.sv =====
// Reply checker for the framed command decoder: watches the config port and both word channels,
// predicts every reply word from the accepted input words and compares field by field.
// Depends on fcd_pkg.
`timescale 1ns / 1ps

module fcd_reply_checker import fcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef enum logic [2:0] {
    WaitA, WaitT, WaitCmd, FanCtlArg, FanRdArg, TempRdArg, HeatCtlArg
  } parse_st_e;

  parse_st_e   parse_st;
  logic        sensor_seen;
  logic        fan_on;
  logic        heat_on;
  logic [14:0] heater_min;
  out_word_t   reply_q[$];
  int          mismatches = 0;

  task automatic decode_word(input in_word_t w);
    logic [7:0] msg [7];
    out_word_t  e;
    int         len;
    len = 0;
    case (parse_st)
      WaitT: parse_st = (w.rx_byte == AsciiT) ? WaitCmd : WaitA;
      WaitCmd: begin
        case (w.rx_byte)
          CmdPing: begin
            parse_st = WaitA;
            msg[0] = AsciiA; msg[1] = AsciiS; msg[2] = CmdPing;
            len = 3;
          end
          CmdTempRd:  parse_st = TempRdArg;
          CmdFanRd:   parse_st = FanRdArg;
          CmdFanCtl:  parse_st = FanCtlArg;
          CmdHeatCtl: parse_st = HeatCtlArg;
          default: ;
        endcase
      end
      FanCtlArg: begin
        parse_st = WaitA;
        if (w.rx_byte == LevelOff) fan_on = 1'b0;
        else if (w.rx_byte == LevelOn) fan_on = 1'b1;
        msg[0] = AsciiA; msg[1] = AsciiS; msg[2] = CmdFanCtl; msg[3] = AckTrailer;
        len = 4;
      end
      FanRdArg: begin
        parse_st = WaitA;
        msg[0] = AsciiA; msg[1] = AsciiS; msg[2] = CmdFanRd;
        msg[3] = 8'h00; msg[4] = 8'h00;
        msg[5] = {1'b0, w.fan_speed[14:8]}; msg[6] = w.fan_speed[7:0];
        len = 7;
      end
      TempRdArg: begin
        parse_st = WaitA;
        msg[0] = AsciiA; msg[3] = 8'h00; msg[4] = 8'h00;
        if (sensor_seen || w.sensor_present) begin
          sensor_seen = 1'b1;
          msg[1] = AsciiS; msg[2] = CmdTempRd;
          msg[5] = w.temperature[15:8]; msg[6] = w.temperature[7:0];
        end else begin
          msg[1] = AsciiE; msg[2] = ErrNoSensor;
          msg[5] = 8'h00; msg[6] = 8'h00;
        end
        len = 7;
      end
      HeatCtlArg: begin
        parse_st = WaitA;
        msg[0] = AsciiA; msg[1] = AsciiS; msg[2] = CmdHeatCtl; msg[3] = AckTrailer;
        if (w.rx_byte == LevelOff) begin
          heat_on = 1'b0;
        end else if (w.rx_byte == LevelOn) begin
          if (w.fan_speed > heater_min) begin
            heat_on = 1'b1;
          end else begin
            msg[1] = AsciiE; msg[2] = ErrRefused;
          end
        end
        len = 4;
      end
      default: parse_st = (w.rx_byte == AsciiA) ? WaitT : WaitA;
    endcase
    for (int k = 0; k < len; k++) begin
      e.reply_byte   = msg[k];
      e.reply_last   = (k == len - 1);
      e.fan_drive    = fan_on;
      e.heater_drive = heat_on;
      reply_q.push_back(e);
    end
  endtask

  task automatic check_reply(input out_word_t got);
    out_word_t exp_w;
    if (reply_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected reply word: expected none, got byte %02h last %0b fan %0b heater %0b",
               $time, got.reply_byte, got.reply_last, got.fan_drive, got.heater_drive);
    end else begin
      exp_w = reply_q.pop_front();
      if (got.reply_byte !== exp_w.reply_byte || got.reply_last !== exp_w.reply_last ||
          got.fan_drive !== exp_w.fan_drive || got.heater_drive !== exp_w.heater_drive) begin
        mismatches++;
        $display("%0t: reply mismatch: expected byte %02h last %0b fan %0b heater %0b, got byte %02h last %0b fan %0b heater %0b",
                 $time, exp_w.reply_byte, exp_w.reply_last, exp_w.fan_drive,
                 exp_w.heater_drive, got.reply_byte, got.reply_last, got.fan_drive,
                 got.heater_drive);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_st    = WaitA;
      sensor_seen = 1'b0;
      fan_on      = 1'b0;
      heat_on     = 1'b0;
      heater_min  = FcdHeaterMinReset;
      reply_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) heater_min = cfg_wdata_i;
      // output first: a reply can never leave in the cycle its command arrives
      if (out_valid_i && !out_stall_i) check_reply(out_word_i);
      if (in_valid_i && !in_stall_i) decode_word(in_word_i);
      pending_o    <= reply_q.size();
      fail_count_o <= mismatches + reply_q.size();
    end
  end

endmodule

// ===== tb/sv/framed_command_decoder_core_tb.sv =====
// Testbench top for framed_command_decoder_core: clock, reset, config writes and
// directed plus random bus-byte stimulus with random stalls.
// Depends on fcd_pkg and fcd_reply_checker.
`timescale 1ns / 1ps

module framed_command_decoder_core_tb import fcd_pkg::*;;

  localparam int CycleLimit = 400000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  in_word_t    in_word_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_word_t   out_word_o;

  int          pending;
  int          fail_count;
  int          cycle_cnt   = 0;
  int          n_words     = 0;
  int          tx_idle_pct = 14;
  int          rx_idle_pct = 75;
  logic [14:0] heater_min  = FcdHeaterMinReset;

  framed_command_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  fcd_reply_checker reply_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [14:0] pick_speed();
    logic [14:0] s;
    case ($urandom_range(5))
      0: s = '0;
      1: s = 15'h7FFF;
      2: s = heater_min;
      3: s = heater_min + 15'd1;
      default: s = 15'($urandom_range(32767));
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_temp();
    logic [15:0] t;
    case ($urandom_range(5))
      0: t = 16'h8000;
      1: t = 16'h7FFF;
      2: t = 16'hFFFF;
      3: t = 16'h0000;
      default: t = 16'($urandom_range(65535));
    endcase
    return t;
  endfunction

  function automatic logic [7:0] unknown_cmd();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CmdPing || c == CmdTempRd || c == CmdFanRd || c == CmdFanCtl ||
           c == CmdHeatCtl)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic [14:0] spd,
                           input logic [15:0] tmp, input logic pres);
    in_word_t w;
    w.rx_byte        = b;
    w.fan_speed      = spd;
    w.temperature    = tmp;
    w.sensor_present = pres;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(b, pick_speed(), pick_temp(), 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [14:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    heater_min  = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_frame();
    logic [7:0] cmd;
    logic [7:0] arg;
    if ($urandom_range(99) < 85) begin
      send_byte(AsciiA);
      send_byte(AsciiT);
      if ($urandom_range(9) == 0) send_byte(unknown_cmd());
      case ($urandom_range(4))
        0: cmd = CmdPing;
        1: cmd = CmdTempRd;
        2: cmd = CmdFanRd;
        3: cmd = CmdFanCtl;
        default: cmd = CmdHeatCtl;
      endcase
      send_byte(cmd);
      if (cmd != CmdPing) begin
        case ($urandom_range(3))
          0: arg = LevelOff;
          1, 2: arg = LevelOn;
          default: arg = 8'($urandom_range(255));
        endcase
        send_byte(arg);
      end
    end else begin
      case ($urandom_range(2))
        0: send_byte(8'($urandom_range(255)));
        1: begin
          send_byte(AsciiA);
          send_byte(8'($urandom_range(255)));
        end
        default: begin
          send_byte(AsciiA);
          send_byte(AsciiT);
          send_byte(($urandom_range(1) == 0) ? unknown_cmd() : 8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad second header byte is not taken as a new start
    send_byte(AsciiA);
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(CmdPing);
    // unknown command keeps waiting for a command
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(8'h55);
    send_byte(CmdPing);
    // temperature read before any sensor, then with one present
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(CmdTempRd);
    send_word(8'hFF, 15'h7FFF, 16'h7FFF, 1'b0);
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(CmdTempRd);
    send_word(8'h00, 15'h0000, 16'h8000, 1'b1);
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(CmdFanRd);
    send_word(8'h80, 15'h7FFF, 16'h0000, 1'b0);
    // heater switch-on refused at exactly the threshold
    send_byte(AsciiA);
    send_byte(AsciiT);
    send_byte(CmdHeatCtl);
    send_word(LevelOn, FcdHeaterMinReset, 16'hFFFF, 1'b1);
    in_valid_i <= 1'b0;
    wait_idle();

    write_cfg(15'd0);
    while (n_words < 160) send_frame();
    in_valid_i <= 1'b0;
    wait_idle();

    tx_idle_pct = 75;
    rx_idle_pct = 14;
    write_cfg(15'h7FFF);
    while (n_words < 315) send_frame();
    in_valid_i <= 1'b0;
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(15'($urandom_range(32767)));
    while (n_words < 470) send_frame();
    in_valid_i <= 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcd_pkg.sv
sv/fcd_parser.sv
sv/fcd_job_fifo.sv
sv/fcd_reply_gen.sv
sv/framed_command_decoder_core.sv
tb/sv/fcd_reply_checker.sv
tb/sv/framed_command_decoder_core_tb.sv
